[hw/rtl/stsc_pkg.sv]
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared sizes, types, register codes and helpers of the submatrix counter.
// ----------------------------------------------------------------------------
package stsc_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int ELEM_W      = 16;
  localparam int CNT_REG_W   = 5;
  localparam int TARGET_W    = 24;
  localparam int PREFIX_W    = 24;
  localparam int TALLY_W     = 15;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_RESET = 16;

  localparam int ROW_IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int COLS_W  = $clog2(MAX_COLS + 1);
  localparam int TOTAL_W = $clog2(STORE_DEPTH + 1);
  localparam int STEP_W  = $clog2(ADDR_W + 1);

  // widest submatrix sum, plus room for the sign-extended target
  localparam int SUM_RAW_W = ELEM_W + ADDR_W + 1;
  localparam int ACC_W     = (SUM_RAW_W > TARGET_W) ? SUM_RAW_W : TARGET_W;

  typedef logic        [CNT_REG_W-1:0]   cnt_reg_t;
  typedef logic        [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic        [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic signed [ELEM_W-1:0]      elem_t;
  typedef logic signed [TARGET_W-1:0]    target_t;
  typedef logic signed [PREFIX_W-1:0]    prefix_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic        [TALLY_W-1:0]     tally_t;
  typedef logic        [ROW_IW-1:0]      row_idx_t;
  typedef logic        [COL_IW-1:0]      col_idx_t;
  typedef logic        [ADDR_W-1:0]      addr_t;
  typedef logic        [ROWS_W-1:0]      rows_t;
  typedef logic        [COLS_W-1:0]      cols_t;
  typedef logic        [TOTAL_W-1:0]     total_t;
  typedef logic        [STEP_W-1:0]      step_t;

  localparam tally_t TALLY_MAX = '1;

  typedef enum cfg_index_t {
    CFG_ROW_COUNT  = 2'd0,
    CFG_COL_COUNT  = 2'd1,
    CFG_TARGET_SUM = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FETCH,
    ST_STORE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic store;
    logic scan_init;
    logic scan_step;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_range;
    logic last_elem;
    logic scan_last;
    logic pipe_empty;
    logic out_free;
  } dp_status_t;

  // zero counts as one, anything past the maximum as the maximum
  function automatic rows_t clamp_rows(input cnt_reg_t v);
    if (v == '0) begin
      return rows_t'(1);
    end else if (int'(v) > MAX_ROWS) begin
      return rows_t'(MAX_ROWS);
    end else begin
      return rows_t'(v);
    end
  endfunction

  function automatic cols_t clamp_cols(input cnt_reg_t v);
    if (v == '0) begin
      return cols_t'(1);
    end else if (int'(v) > MAX_COLS) begin
      return cols_t'(MAX_COLS);
    end else begin
      return cols_t'(v);
    end
  endfunction

  function automatic addr_t make_addr(input row_idx_t row, input col_idx_t col);
    return addr_t'(row) * addr_t'(MAX_COLS) + addr_t'(col);
  endfunction

endpackage

[hw/rtl/stsc_if.sv]
// ----------------------------------------------------------------------------
// stsc_if
// Valid/ready channels for element words in and count words out.
// ----------------------------------------------------------------------------
interface stsc_elem_if;
  logic            valid;
  logic            ready;
  stsc_pkg::elem_t element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface stsc_count_if;
  logic             valid;
  logic             ready;
  stsc_pkg::tally_t match_count;

  modport source (output valid, output match_count, input ready);
  modport sink   (input valid, input match_count, output ready);
endinterface

[hw/rtl/stsc_divider.sv]
// ----------------------------------------------------------------------------
// stsc_divider
// Restoring divider, one quotient bit per cycle: load position by column count.
// ----------------------------------------------------------------------------
module stsc_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  stsc_pkg::addr_t    dividend,
  input  stsc_pkg::cols_t    divisor,
  output logic               done,
  output stsc_pkg::addr_t    quotient,
  output stsc_pkg::col_idx_t remainder
);

  logic                       busy;
  stsc_pkg::step_t            step;
  stsc_pkg::addr_t            quo;
  stsc_pkg::cols_t            dvsr;
  stsc_pkg::cols_t            rem;
  logic [stsc_pkg::COLS_W:0]  rem_sh;
  logic                       fits;

  always_comb begin
    rem_sh = {rem, quo[stsc_pkg::ADDR_W-1]};
    fits   = rem_sh >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= stsc_pkg::step_t'(stsc_pkg::ADDR_W);
    end else if (busy) begin
      step <= step - stsc_pkg::step_t'(1);
      if (step == stsc_pkg::step_t'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= stsc_pkg::addr_t'({quo, fits});
      rem <= fits ? stsc_pkg::cols_t'(rem_sh - {1'b0, dvsr}) : stsc_pkg::cols_t'(rem_sh);
    end
  end

  assign done      = !busy;
  assign quotient  = quo;
  assign remainder = rem[stsc_pkg::COL_IW-1:0];

endmodule

[hw/rtl/stsc_ctrl.sv]
// ----------------------------------------------------------------------------
// stsc_ctrl
// Sequencer: element load, submatrix scan, drain and result hand-off.
// ----------------------------------------------------------------------------
module stsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stsc_pkg::dp_status_t status,
  output stsc_pkg::ctrl_cmd_t  cmd
);

  stsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      stsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = stsc_pkg::ST_DIVIDE;
        end
      end
      stsc_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = status.in_range ? stsc_pkg::ST_FETCH : stsc_pkg::ST_STORE;
        end
      end
      stsc_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = stsc_pkg::ST_STORE;
      end
      stsc_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        if (status.last_elem) begin
          cmd.scan_init = 1'b1;
          state_next    = stsc_pkg::ST_SCAN;
        end else begin
          state_next = stsc_pkg::ST_IDLE;
        end
      end
      stsc_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = stsc_pkg::ST_DRAIN;
        end
      end
      stsc_pkg::ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = stsc_pkg::ST_FINISH;
        end
      end
      stsc_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = stsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/stsc_datapath.sv]
// ----------------------------------------------------------------------------
// stsc_datapath
// Config registers, column prefix store, scan counters, sum pipeline, output.
// ----------------------------------------------------------------------------
module stsc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  stsc_pkg::cfg_index_t cfg_index,
  input  stsc_pkg::cfg_data_t  cfg_data,
  input  stsc_pkg::elem_t      in_element,
  input  stsc_pkg::ctrl_cmd_t  cmd,
  output stsc_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stsc_pkg::tally_t     out_count
);

  stsc_pkg::cnt_reg_t  row_cfg, col_cfg;
  stsc_pkg::target_t   target_cfg, target_q;
  stsc_pkg::rows_t     rows_c, rows_q;
  stsc_pkg::cols_t     cols_c, cols_q;
  stsc_pkg::total_t    total_c, pos_inc;
  stsc_pkg::elem_t     elem;
  stsc_pkg::addr_t     pos;
  logic                in_range, last_elem;

  logic                div_done;
  stsc_pkg::addr_t     quotient;
  stsc_pkg::col_idx_t  div_col;
  stsc_pkg::row_idx_t  div_row;
  logic                div_row_zero;

  stsc_pkg::prefix_t   prefix_mem [stsc_pkg::STORE_DEPTH];
  stsc_pkg::prefix_t   rd_a, rd_b, above, wr_data;
  stsc_pkg::addr_t     rd_addr_a, rd_addr_b, wr_addr;
  logic                wr_en;

  stsc_pkg::row_idx_t  top, bot;
  stsc_pkg::col_idx_t  left, col;
  logic                col_last, left_last, bot_last, top_last;

  logic                s1_valid, s1_first, s1_top_zero;
  logic                s2_valid, s2_first;
  stsc_pkg::acc_t      diff, diff_next, acc, acc_next;
  logic                hit;
  stsc_pkg::tally_t    tally;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cfg    <= stsc_pkg::cnt_reg_t'(stsc_pkg::COUNT_RESET);
      col_cfg    <= stsc_pkg::cnt_reg_t'(stsc_pkg::COUNT_RESET);
      target_cfg <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        stsc_pkg::CFG_ROW_COUNT:  row_cfg    <= cfg_data[stsc_pkg::CNT_REG_W-1:0];
        stsc_pkg::CFG_COL_COUNT:  col_cfg    <= cfg_data[stsc_pkg::CNT_REG_W-1:0];
        stsc_pkg::CFG_TARGET_SUM: target_cfg <= stsc_pkg::target_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign rows_c  = stsc_pkg::clamp_rows(row_cfg);
  assign cols_c  = stsc_pkg::clamp_cols(col_cfg);
  assign total_c = stsc_pkg::total_t'(rows_c) * stsc_pkg::total_t'(cols_c);
  assign pos_inc = stsc_pkg::total_t'(pos) + stsc_pkg::total_t'(1);

  // word capture; counts are frozen with each word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      elem      <= in_element;
      rows_q    <= rows_c;
      cols_q    <= cols_c;
      target_q  <= target_cfg;
      in_range  <= stsc_pkg::total_t'(pos) < total_c;
      last_elem <= pos_inc >= total_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.store) begin
      pos <= last_elem ? '0 : stsc_pkg::addr_t'(pos_inc);
    end
  end

  stsc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.accept),
    .dividend  (pos),
    .divisor   (cols_c),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (div_col)
  );

  assign div_row      = quotient[stsc_pkg::ROW_IW-1:0];
  assign div_row_zero = (quotient == '0);

  // prefix store: one write port, two registered read ports
  always_comb begin
    if (cmd.fetch) begin
      rd_addr_a = stsc_pkg::make_addr(div_row - stsc_pkg::row_idx_t'(1), div_col);
    end else begin
      rd_addr_a = stsc_pkg::make_addr(bot, col);
    end
    rd_addr_b = stsc_pkg::make_addr(top - stsc_pkg::row_idx_t'(1), col);
    wr_addr   = stsc_pkg::make_addr(div_row, div_col);
    above     = div_row_zero ? '0 : rd_a;
    wr_data   = above + stsc_pkg::prefix_t'(elem);
    wr_en     = cmd.store && in_range;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_mem[wr_addr] <= wr_data;
    end
    rd_a <= prefix_mem[rd_addr_a];
    rd_b <= prefix_mem[rd_addr_b];
  end

  // scan order: top, bottom, left, right edge
  always_comb begin
    col_last  = (stsc_pkg::cols_t'(col)  + stsc_pkg::cols_t'(1)) == cols_q;
    left_last = (stsc_pkg::cols_t'(left) + stsc_pkg::cols_t'(1)) == cols_q;
    bot_last  = (stsc_pkg::rows_t'(bot)  + stsc_pkg::rows_t'(1)) == rows_q;
    top_last  = (stsc_pkg::rows_t'(top)  + stsc_pkg::rows_t'(1)) == rows_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      top  <= '0;
      bot  <= '0;
      left <= '0;
      col  <= '0;
    end else if (cmd.scan_step) begin
      if (!col_last) begin
        col <= col + stsc_pkg::col_idx_t'(1);
      end else if (!left_last) begin
        left <= left + stsc_pkg::col_idx_t'(1);
        col  <= left + stsc_pkg::col_idx_t'(1);
      end else if (!bot_last) begin
        bot  <= bot + stsc_pkg::row_idx_t'(1);
        left <= '0;
        col  <= '0;
      end else if (!top_last) begin
        top  <= top + stsc_pkg::row_idx_t'(1);
        bot  <= top + stsc_pkg::row_idx_t'(1);
        left <= '0;
        col  <= '0;
      end
    end
  end

  // stage 1: read data back, column block sum; stage 2: run along the row
  always_comb begin
    diff_next = stsc_pkg::acc_t'(rd_a) - (s1_top_zero ? '0 : stsc_pkg::acc_t'(rd_b));
    acc_next  = (s2_first ? '0 : acc) + diff;
    hit       = s2_valid && (acc_next == stsc_pkg::acc_t'(target_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_step;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first    <= (col == left);
    s1_top_zero <= (top == '0);
    s2_first    <= s1_first;
    diff        <= diff_next;
    if (s2_valid) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      tally <= '0;
    end else if (hit && (tally != stsc_pkg::TALLY_MAX)) begin
      tally <= tally + stsc_pkg::tally_t'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_count <= tally;
    end
  end

  always_comb begin
    status.div_done   = div_done;
    status.in_range   = in_range;
    status.last_elem  = last_elem;
    status.scan_last  = col_last && left_last && bot_last && top_last;
    status.pipe_empty = !s1_valid && !s2_valid;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

[hw/rtl/submatrix_target_sum_counter_unit.sv]
// ----------------------------------------------------------------------------
// submatrix_target_sum_counter_unit
// Counts the submatrices of a loaded matrix whose element sum hits a target.
//
// Elements arrive one word at a time in row-major order on in_ch; the row
// count, column count and target sum come from the write port (a count of
// zero acts as one, a count above 16 acts as 16). While loading, each
// element is added to the running sum of its column and kept in a 256-entry
// prefix store. The word that completes rows*cols elements starts the count:
// every submatrix (top row, bottom row, left column, right column) is
// visited once, one per cycle, and the single count word goes out on
// out_ch. Each element is loaded in steps: accept, the one-bit-per-cycle
// divider that splits the load position into row and column, a store
// read, a store write. The scan reads the sums through the two read ports
// of the prefix store. The count word sits in an output register, so
// loading of the next matrix goes on while it waits to be taken. The
// prefix store needs no clearing after reset.
// ----------------------------------------------------------------------------
module submatrix_target_sum_counter_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  stsc_pkg::cfg_index_t cfg_index,
  input  stsc_pkg::cfg_data_t  cfg_data,
  stsc_elem_if.sink            in_ch,
  stsc_count_if.source         out_ch
);

  // command and status between sequencer and datapath
  stsc_pkg::ctrl_cmd_t  cmd;
  stsc_pkg::dp_status_t status;

  // sequencer: owns in_ch.ready; only idle while waiting for the next word
  stsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config, prefix store, scan pipeline, output register
  stsc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_element   (in_ch.element),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_count    (out_ch.match_count)
  );

endmodule

[hw/rtl/stsc_checker.sv]
// ----------------------------------------------------------------------------
// stsc_checker
// Port-level checks for the submatrix counter, bound to the top level.
// ----------------------------------------------------------------------------
module stsc_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input stsc_pkg::tally_t match_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("count word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(match_count))
    else $error("count word changed while stalled");

  // each element passes through divide and store before the next is taken, so no two words back to back
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a count word only comes out of the busy phase, never straight from idle
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("count word raised while input side was idle");

endmodule

bind submatrix_target_sum_counter_unit stsc_checker u_stsc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .match_count (out_ch.match_count)
);
